// File: design/crcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfs_pkg
// shared types, codes and the crc-16 byte fold for the frame sender
// ----------------------------------------------------------------------------
package crcfs_pkg;

    localparam logic [7:0]  HDR_SOH  = 8'h01;
    localparam logic [7:0]  HDR_EOT  = 8'h04;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic OUT_KIND_BYTE    = 1'b0;
    localparam logic OUT_KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_RESEND  = 2'd1,
        VERDICT_GIVE_UP = 2'd2
    } t_verdict;

    // position inside the byte run of one payload item
    typedef enum logic [2:0] {
        STEP_HDR    = 3'd0,
        STEP_SEQ    = 3'd1,
        STEP_INV    = 3'd2,
        STEP_DATA   = 3'd3,
        STEP_CRC_HI = 3'd4,
        STEP_CRC_LO = 3'd5
    } t_step;

    // work handed from the front end to the back end
    typedef struct packed {
        logic        is_resp;
        logic        start;
        logic        last;
        logic        final_frame;
        logic [7:0]  seq;
        logic [7:0]  data;
        logic [15:0] crc;
        t_verdict    verdict;
    } t_cmd;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: design/crcfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfs_front
// accepts items, tracks frame state and crc, judges responses
// ----------------------------------------------------------------------------
module crcfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [7:0]        i_seq,
    input  logic              i_final_frame,
    input  logic              i_timed_out,
    input  logic              i_q_full,
    output logic              o_push,
    output crcfs_pkg::t_cmd   o_cmd
);

    logic [3:0]  r_retry_limit;
    logic [15:0] r_crc;
    logic        r_in_frame;
    logic        r_frame_is_final;
    logic [3:0]  r_failed_tries;

    logic [15:0] n_crc;
    logic        n_in_frame;
    logic        n_frame_is_final;
    logic [3:0]  n_failed_tries;

    logic              accept;
    logic              fin_eff;
    logic              failed;
    logic [4:0]        tries_inc;
    crcfs_pkg::t_verdict verd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign accept      = i_valid && o_ready;

    assign fin_eff   = r_in_frame ? r_frame_is_final : i_final_frame;
    assign tries_inc = {1'b0, r_failed_tries} + 5'd1;
    assign failed    = i_timed_out ? !r_frame_is_final : (i_data_byte != 8'h00);

    always_comb begin
        n_crc            = r_crc;
        n_in_frame       = r_in_frame;
        n_frame_is_final = r_frame_is_final;
        n_failed_tries   = r_failed_tries;
        verd             = crcfs_pkg::VERDICT_ACCEPT;
        o_push           = 1'b0;
        if (i_kind == crcfs_pkg::KIND_PAYLOAD) begin
            n_crc            = crcfs_pkg::crc_fold(r_in_frame ? r_crc : 16'h0000, i_data_byte);
            n_in_frame       = !i_last_byte;
            n_frame_is_final = fin_eff;
            o_push           = accept;
        end else if (!r_in_frame) begin
            o_push = accept;
            if (!failed) begin
                n_failed_tries = 4'd0;
                verd           = crcfs_pkg::VERDICT_ACCEPT;
            end else if (tries_inc >= {1'b0, r_retry_limit}) begin
                n_failed_tries = 4'd0;
                verd           = crcfs_pkg::VERDICT_GIVE_UP;
            end else begin
                n_failed_tries = tries_inc[3:0];
                verd           = crcfs_pkg::VERDICT_RESEND;
            end
        end
    end

    always_comb begin
        o_cmd.is_resp     = (i_kind == crcfs_pkg::KIND_RESPONSE);
        o_cmd.start       = !r_in_frame;
        o_cmd.last        = i_last_byte;
        o_cmd.final_frame = fin_eff;
        o_cmd.seq         = i_seq;
        o_cmd.data        = i_data_byte;
        o_cmd.crc         = n_crc;
        o_cmd.verdict     = verd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit    <= crcfs_pkg::RETRY_LIMIT_RESET;
            r_crc            <= 16'h0000;
            r_in_frame       <= 1'b0;
            r_frame_is_final <= 1'b0;
            r_failed_tries   <= 4'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_retry_limit <= i_cfg_data;
            end
            if (accept) begin
                r_crc            <= n_crc;
                r_in_frame       <= n_in_frame;
                r_frame_is_final <= n_frame_is_final;
                r_failed_tries   <= n_failed_tries;
            end
        end
    end

endmodule

// File: design/crcfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfs_queue
// small command fifo between front end and back end
// ----------------------------------------------------------------------------
module crcfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crcfs_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output crcfs_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crcfs_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: design/crcfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfs_back
// expands queued commands into frame bytes and verdicts, one result a cycle while i_ready is high
// ----------------------------------------------------------------------------
module crcfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  crcfs_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [7:0]      o_byte,
    output logic [1:0]      o_verdict,
    output logic            o_last
);

    logic             r_busy;
    crcfs_pkg::t_step r_step;
    logic             n_busy;
    crcfs_pkg::t_step n_step;

    logic             r_out_valid;
    logic             r_out_kind;
    logic [7:0]       r_out_byte;
    logic [1:0]       r_out_verdict;
    logic             r_out_last;

    crcfs_pkg::t_step cur_step;
    crcfs_pkg::t_step end_step;
    logic             load;
    logic             run_end;
    logic [7:0]       sel_byte;

    assign load     = i_q_valid && (!r_out_valid || i_ready);
    assign cur_step = r_busy ? r_step
                    : ((i_cmd.start && !i_cmd.is_resp) ? crcfs_pkg::STEP_HDR
                                                       : crcfs_pkg::STEP_DATA);
    assign end_step = (i_cmd.last && !i_cmd.is_resp) ? crcfs_pkg::STEP_CRC_LO
                                                     : crcfs_pkg::STEP_DATA;
    assign run_end  = (cur_step == end_step);
    assign o_pop    = load && run_end;

    // next step
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (load) begin
            if (run_end) begin
                n_busy = 1'b0;
            end else begin
                n_busy = 1'b1;
                n_step = crcfs_pkg::t_step'(3'(cur_step) + 3'd1);
            end
        end
    end

    // byte for the current step
    always_comb begin
        unique case (cur_step)
            crcfs_pkg::STEP_HDR:
                sel_byte = i_cmd.final_frame ? crcfs_pkg::HDR_EOT : crcfs_pkg::HDR_SOH;
            crcfs_pkg::STEP_SEQ:    sel_byte = i_cmd.seq;
            crcfs_pkg::STEP_INV:    sel_byte = ~i_cmd.seq;
            crcfs_pkg::STEP_DATA:   sel_byte = i_cmd.data;
            crcfs_pkg::STEP_CRC_HI: sel_byte = i_cmd.crc[15:8];
            crcfs_pkg::STEP_CRC_LO: sel_byte = i_cmd.crc[7:0];
            default:                sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= crcfs_pkg::STEP_HDR;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_last <= run_end;
            if (i_cmd.is_resp) begin
                r_out_kind    <= crcfs_pkg::OUT_KIND_VERDICT;
                r_out_byte    <= 8'h00;
                r_out_verdict <= i_cmd.verdict;
            end else begin
                r_out_kind    <= crcfs_pkg::OUT_KIND_BYTE;
                r_out_byte    <= sel_byte;
                r_out_verdict <= crcfs_pkg::VERDICT_ACCEPT;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_out_kind;
    assign o_byte    = r_out_byte;
    assign o_verdict = r_out_verdict;
    assign o_last    = r_out_last;

endmodule

// File: design/crc16_block_frame_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_block_frame_sender_core
// sender side of a block transfer with crc-16 framed packets
// ----------------------------------------------------------------------------
// Feed payload bytes (tuser 0) with tlast on the frame's last byte; the block
// wraps them into a frame: a header byte (soh for a data frame, eot for the
// final frame), the sequence number and its complement, the payload passed
// through, then a crc-16 (poly 0x1021, init 0), high byte first. Feed the
// partner's reply (tuser 1) after a frame; it comes back as one verdict:
// accepted, resend the same frame, or give up after retry_limit failed tries.
// A mid-frame byte is taken every cycle while the queue has room and gives one
// output item; the first byte of a frame gives four output items and the last
// byte three, so the output side, which emits one item per cycle from the back
// end while m_axis_tready is high, sets the throughput over a frame. A 4-entry
// command queue between the front end (framing state, crc fold, reply judgment)
// and the back end (byte expansion) lets input keep streaming while header or
// crc bytes drain. Accepted items pass the queue, then the output register.
module crc16_block_frame_sender_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: retry_limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], seq[15:8], final_frame[16],
                                        // timed_out[17], zero pad[23:18]
    input  logic        s_axis_tuser,   // kind
    input  logic        s_axis_tlast,   // last_byte
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], verdict[9:8], zero pad[15:10]
    output logic        m_axis_tuser,   // out_kind
    output logic        m_axis_tlast    // run_last
);

    // front end to queue
    logic            front_push;
    crcfs_pkg::t_cmd front_cmd;
    logic            q_full;

    // queue to back end
    logic            q_valid;
    crcfs_pkg::t_cmd q_cmd;
    logic            back_pop;

    logic [7:0]      out_byte;
    logic [1:0]      out_verdict;

    crcfs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_last_byte   (s_axis_tlast),
        .i_seq         (s_axis_tdata[15:8]),
        .i_final_frame (s_axis_tdata[16]),
        .i_timed_out   (s_axis_tdata[17]),
        .i_q_full      (q_full),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    crcfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    crcfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (back_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_byte    (out_byte),
        .o_verdict (out_verdict),
        .o_last    (m_axis_tlast)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {6'b000000, out_verdict, out_byte};

endmodule
